>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked check with active-low reset masking.
`define PRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Shorthand on the block clock and reset.
`define PRC_CHECK(label, prop, msg) `PRC_ASSERT(label, i_clk, i_rst_n, prop, msg)

`endif

>>> hdl/prc_pkg.sv
`default_nettype none

package prc_pkg;

    localparam int MAX_COLUMNS_DEF  = 16;
    localparam int SCORE_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF   = 40;

    localparam int CFG_BITS         = 5;
    localparam int ROW_LENGTH_RESET = 2;
    localparam int MIN_ROW_LENGTH   = 2;

    // Q16 ratio: 16 fraction bits, one integer bit so that 1.0 is representable
    localparam int FRAC_BITS = 16;
    localparam int Q_BITS    = 17;
    localparam logic [Q_BITS-1:0] Q_ONE = Q_BITS'(1) << FRAC_BITS;

    typedef struct packed {
        logic col_accept;   // take the column on the input channel
        logic div_start;    // counters are final, start the ratio
        logic load_out;     // move ratio and counts to the output register
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

>>> hdl/prc_in_if.sv
`default_nettype none

interface prc_in_if #(
    parameter int SCORE_BITS = prc_pkg::SCORE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [SCORE_BITS-1:0] score_a;
    logic signed [SCORE_BITS-1:0] score_b;
    logic                         end_of_set;

    modport source (output valid, output score_a, output score_b, output end_of_set,
                    input ready);
    modport sink   (input valid, input score_a, input score_b, input end_of_set,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/prc_out_if.sv
`default_nettype none

interface prc_out_if #(
    parameter int COUNT_BITS = prc_pkg::COUNT_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [prc_pkg::Q_BITS-1:0]  concordance_q16;
    logic [COUNT_BITS-1:0]       concordant_pairs;
    logic [COUNT_BITS-1:0]       total_pairs;

    modport source (output valid, output concordance_q16, output concordant_pairs,
                    output total_pairs, input ready);
    modport sink   (input valid, input concordance_q16, input concordant_pairs,
                    input total_pairs, output ready);
endinterface

`default_nettype wire

>>> hdl/prc_div.sv
`default_nettype none
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle: floor(num*2^16/den), max 1.0.
module prc_div #(
    parameter int COUNT_BITS = prc_pkg::COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [COUNT_BITS-1:0]      i_num,
    input  logic [COUNT_BITS-1:0]      i_den,
    output logic                       o_busy,
    output logic [prc_pkg::Q_BITS-1:0] o_quot
);
    import prc_pkg::*;

    localparam int REM_BITS = COUNT_BITS + 1;
    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

    logic                  r_busy;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [REM_BITS-1:0]   r_rem;
    logic [COUNT_BITS-1:0] r_den;
    logic [Q_BITS-1:0]     r_quot;

    logic [REM_BITS-1:0] w_shift;
    logic [REM_BITS-1:0] w_den_ext;
    logic                w_ge;
    logic                w_trivial;

    // rem < den always holds, so the doubled remainder fits REM_BITS
    assign w_shift   = {r_rem[REM_BITS-2:0], 1'b0};
    assign w_den_ext = {1'b0, r_den};
    assign w_ge      = (w_shift >= w_den_ext);
    // no pairs, or all pairs agree: no iteration needed
    assign w_trivial = (i_den == '0) || (i_num >= i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !w_trivial;
            r_cnt  <= CNT_BITS'(FRAC_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= {1'b0, i_num};
            r_quot <= (i_den != '0 && i_num >= i_den) ? Q_ONE : '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_shift - w_den_ext) : w_shift;
            r_quot <= {r_quot[Q_BITS-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

    `PRC_CHECK(a_div_rem_below_den, r_busy |-> (r_rem < w_den_ext), "divider remainder not below divisor")

endmodule

`default_nettype wire

>>> hdl/prc_dp.sv
`default_nettype none
`include "assert_macros.svh"

module prc_dp #(
    parameter int MAX_COLUMNS = prc_pkg::MAX_COLUMNS_DEF,
    parameter int SCORE_BITS  = prc_pkg::SCORE_BITS_DEF,
    parameter int COUNT_BITS  = prc_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  prc_pkg::t_cmd                i_cmd,
    output prc_pkg::t_stat               o_stat,
    input  logic                         i_cfg_we,
    input  logic [prc_pkg::CFG_BITS-1:0] i_cfg_wdata,
    input  logic signed [SCORE_BITS-1:0] i_score_a,
    input  logic signed [SCORE_BITS-1:0] i_score_b,
    input  logic                         i_end_of_set,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [prc_pkg::Q_BITS-1:0]   o_concordance_q16,
    output logic [COUNT_BITS-1:0]        o_concordant_pairs,
    output logic [COUNT_BITS-1:0]        o_total_pairs
);
    import prc_pkg::*;

    localparam int POS_BITS = $clog2(MAX_COLUMNS);
    localparam int LEN_BITS = $clog2(MAX_COLUMNS + 1);
    localparam int CMP_BITS = (LEN_BITS > CFG_BITS) ? LEN_BITS : CFG_BITS;

    // configuration and row storage
    logic [CFG_BITS-1:0]          r_row_length;
    logic signed [SCORE_BITS-1:0] r_a [MAX_COLUMNS];
    logic signed [SCORE_BITS-1:0] r_b [MAX_COLUMNS];
    logic [POS_BITS-1:0]          r_pos;

    // compare stage -> accumulate stage
    logic                   r_pend;
    logic [MAX_COLUMNS-1:0] r_mask;
    logic [POS_BITS-1:0]    r_npairs;

    logic [COUNT_BITS-1:0]  r_agree;
    logic [COUNT_BITS-1:0]  r_pairs;
    logic [COUNT_BITS-1:0]  n_agree;
    logic [COUNT_BITS-1:0]  n_pairs;

    logic                   r_out_valid;
    logic [Q_BITS-1:0]      r_out_q;
    logic [COUNT_BITS-1:0]  r_out_agree;
    logic [COUNT_BITS-1:0]  r_out_pairs;

    logic [CMP_BITS-1:0]    w_rl;
    logic [LEN_BITS-1:0]    w_len;
    logic [POS_BITS-1:0]    w_pos;
    logic [LEN_BITS-1:0]    w_pos_inc;
    logic [POS_BITS-1:0]    w_pos_next;
    logic [MAX_COLUMNS-1:0] w_mask;
    logic [LEN_BITS-1:0]    w_cnt;
    logic [COUNT_BITS:0]    w_sum_agree;
    logic [COUNT_BITS:0]    w_sum_pairs;
    logic                   w_div_busy;
    logic [Q_BITS-1:0]      w_quot;

    // effective row length, clamped to [2, MAX_COLUMNS]
    assign w_rl = CMP_BITS'(r_row_length);
    always_comb begin
        priority if (w_rl < CMP_BITS'(MIN_ROW_LENGTH)) begin
            w_len = LEN_BITS'(MIN_ROW_LENGTH);
        end else if (w_rl > CMP_BITS'(MAX_COLUMNS)) begin
            w_len = LEN_BITS'(MAX_COLUMNS);
        end else begin
            w_len = LEN_BITS'(w_rl);
        end
    end

    // a shortened row length restarts the row
    assign w_pos      = (LEN_BITS'(r_pos) >= w_len) ? '0 : r_pos;
    assign w_pos_inc  = LEN_BITS'(w_pos) + LEN_BITS'(1);
    assign w_pos_next = (i_end_of_set || (w_pos_inc >= w_len)) ? '0 : POS_BITS'(w_pos_inc);

    // one comparator pair per stored column
    always_comb begin
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            w_mask[i] = (POS_BITS'(i) < w_pos) &&
                        ((r_a[i] < i_score_a) == (r_b[i] < i_score_b));
        end
    end

    always_comb begin
        w_cnt = '0;
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            w_cnt = w_cnt + LEN_BITS'(r_mask[i]);
        end
    end

    assign w_sum_agree = {1'b0, r_agree} + (COUNT_BITS + 1)'(w_cnt);
    assign w_sum_pairs = {1'b0, r_pairs} + (COUNT_BITS + 1)'(r_npairs);
    assign n_agree = w_sum_agree[COUNT_BITS] ? '1 : w_sum_agree[COUNT_BITS-1:0];
    assign n_pairs = w_sum_pairs[COUNT_BITS] ? '1 : w_sum_pairs[COUNT_BITS-1:0];

    prc_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_agree),
        .i_den   (r_pairs),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= CFG_BITS'(ROW_LENGTH_RESET);
            r_pos        <= '0;
            r_pend       <= 1'b0;
            r_agree      <= '0;
            r_pairs      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_row_length <= i_cfg_wdata;
            end
            if (i_cmd.col_accept) begin
                r_pos <= w_pos_next;
            end
            r_pend <= i_cmd.col_accept;
            if (r_pend) begin
                r_agree <= n_agree;
                r_pairs <= n_pairs;
            end else if (i_cmd.load_out) begin
                r_agree <= '0;
                r_pairs <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.col_accept) begin
            r_a[w_pos] <= i_score_a;
            r_b[w_pos] <= i_score_b;
            r_mask     <= w_mask;
            r_npairs   <= w_pos;
        end
        if (i_cmd.load_out) begin
            r_out_q     <= w_quot;
            r_out_agree <= r_agree;
            r_out_pairs <= r_pairs;
        end
    end

    assign o_stat = '{div_busy: w_div_busy, out_busy: r_out_valid};

    assign o_out_valid        = r_out_valid;
    assign o_concordance_q16  = r_out_q;
    assign o_concordant_pairs = r_out_agree;
    assign o_total_pairs      = r_out_pairs;

    `PRC_CHECK(a_dp_agree_le_pairs, r_agree <= r_pairs, "concordant count above pair count")
    `PRC_CHECK(a_dp_load_after_flush, i_cmd.load_out |-> !r_pend, "result loaded with column pending")

endmodule

`default_nettype wire

>>> hdl/prc_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module prc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_end_of_set,
    output logic           o_in_ready,
    input  prc_pkg::t_stat i_stat,
    output prc_pkg::t_cmd  o_cmd
);
    import prc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FLUSH = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_LOAD  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.col_accept = i_in_valid;
                if (i_in_valid && i_end_of_set) begin
                    n_state = S_FLUSH;
                end
            end
            // last column's counts land in the counters
            S_FLUSH: begin
                n_state = S_START;
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PRC_CHECK(a_ctrl_hold_after_eos, (i_in_valid && o_in_ready && i_end_of_set) |=> !o_in_ready, "input taken while set result pending")

endmodule

`default_nettype wire

>>> hdl/pairwise_rank_concordance_top.sv
// Rank concordance of two score streams; one column item per cycle while a row streams in.
// After an end-of-set item the controller steps through FLUSH, START, DIV and LOAD before the result is valid;
//   DIV waits on the one-bit-per-cycle ratio divider, which skips iterating when no pairs or all agree.
// Throughput: 1 item/cycle for ordinary columns; after an end-of-set item input stalls until
//   the result is in the output register.
// Reset: synchronous active-low; counters, row position and row_length (=2) reset, stored scores don't.
`default_nettype none

module pairwise_rank_concordance_top #(
    parameter int MAX_COLUMNS = prc_pkg::MAX_COLUMNS_DEF,
    parameter int SCORE_BITS  = prc_pkg::SCORE_BITS_DEF,
    parameter int COUNT_BITS  = prc_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [prc_pkg::CFG_BITS-1:0] i_cfg_wdata,
    prc_in_if.sink                       i_in,
    prc_out_if.source                    o_out
);
    import prc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    // Controller: accepts columns in IDLE, then sequences flush, divide and
    // result load once an end-of-set item has been taken.
    prc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_end_of_set (i_in.end_of_set),
        .o_in_ready   (w_in_ready),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    // Datapath: row store with parallel comparators, a registered agree mask,
    // saturating counters that add the mask in the following cycle, divider and output register.
    prc_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .SCORE_BITS  (SCORE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_score_a          (i_in.score_a),
        .i_score_b          (i_in.score_b),
        .i_end_of_set       (i_in.end_of_set),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_concordance_q16  (o_out.concordance_q16),
        .o_concordant_pairs (o_out.concordant_pairs),
        .o_total_pairs      (o_out.total_pairs)
    );

    assign i_in.ready = w_in_ready;

endmodule

`default_nettype wire
